### src/pdrg_pkg.sv
package pdrg_pkg;

   // Register map of the configuration port
   typedef enum logic [2:0] {
      REG_ROT_ROW_X  = 3'd0,
      REG_ROT_ROW_Y  = 3'd1,
      REG_ROT_ROW_Z  = 3'd2,
      REG_SHIFT_X    = 3'd3,
      REG_SHIFT_Y    = 3'd4,
      REG_SHIFT_Z    = 3'd5,
      REG_RANGE      = 3'd6,
      REG_KEEP_EVERY = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 48;
   localparam int ROW_WIDTH       = 48;
   localparam int SHIFT_WIDTH     = 24;
   localparam int RANGE_FIELD     = 24;
   localparam int RANGE_WIDTH     = 2 * RANGE_FIELD;
   localparam int RANGE_SQ_WIDTH  = 2 * RANGE_FIELD;
   localparam int KEEP_WIDTH      = 16;

   // Identity rotation in Q2.14, empty range gate (min above max)
   localparam logic [ROW_WIDTH-1:0]   ROT_ROW_X_RESET = 48'h0000_0000_4000;
   localparam logic [ROW_WIDTH-1:0]   ROT_ROW_Y_RESET = 48'h0000_4000_0000;
   localparam logic [ROW_WIDTH-1:0]   ROT_ROW_Z_RESET = 48'h4000_0000_0000;
   localparam logic [RANGE_WIDTH-1:0] RANGE_RESET     = 48'h7FFF_FFFF_0000;
   localparam logic [KEEP_WIDTH-1:0]  KEEP_RESET      = 16'd1;

endpackage

### src/point_decimate_range_gate_transform_top.sv
// Point decimation, range gate and rigid transform. Each req transaction carries one
// signed Q12.12 point; within a cloud (restarted by req_tuser) one point in keep_every
// is kept, starting with the first, and dropped points give no rsp transaction. A kept
// point whose squared norm lies below min^2 or above max^2 is zeroed, then rotated by
// the 3x3 Q2.14 matrix, rounded half up, offset by the translation and clipped to
// COORD_WIDTH bits. One point is taken every clock cycle while the output is not
// stalled; a result passes through the input register, the multiplier register and
// the output register, and each stage holds its item only while the stage after it is
// full and stalled. Configuration writes are taken in any cycle and should be issued
// while no point is in flight; the squared range limits are registered from the range
// register and so follow a write to it in the next cycle.
module point_decimate_range_gate_transform_top #(
   parameter int COORD_WIDTH = 24,
   parameter int COEF_WIDTH  = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // req_tdata: point_x, point_y, point_z, zero pad to whole bytes
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]         req_tdata,
   // req_tuser: cloud_start
   input  logic                                       req_tuser,
   // rsp_tdata: world_x, world_y, world_z, zero pad to whole bytes
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // rsp_tuser: out_of_range, saturated
   output logic [1:0]                                 rsp_tuser,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [pdrg_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [pdrg_pkg::CSR_DATA_WIDTH-1:0]        csr_data
);

   localparam int TDATA_WIDTH = ((3*COORD_WIDTH+7)/8)*8;
   localparam int PAD_WIDTH   = TDATA_WIDTH - 3*COORD_WIDTH;
   localparam int ROW_EXT     = (3*COEF_WIDTH > pdrg_pkg::ROW_WIDTH) ?
                                3*COEF_WIDTH : pdrg_pkg::ROW_WIDTH;
   localparam int SH_EXT      = (COORD_WIDTH > pdrg_pkg::SHIFT_WIDTH) ?
                                COORD_WIDTH : pdrg_pkg::SHIFT_WIDTH;
   localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH   = COORD_WIDTH + COEF_WIDTH + 2;
   localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
   localparam int CMP_WIDTH   = (SQ_WIDTH > pdrg_pkg::RANGE_SQ_WIDTH) ?
                                SQ_WIDTH : pdrg_pkg::RANGE_SQ_WIDTH;
   localparam int FRAC_SHIFT  = COEF_WIDTH - 2;
   localparam int HEAD_WIDTH  = ACC_WIDTH - COORD_WIDTH + 1;
   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
      signed'(ACC_WIDTH'(1) << (FRAC_SHIFT - 1));

   // ---------------- configuration ----------------
   logic [pdrg_pkg::ROW_WIDTH-1:0]      rot_ff   [3];
   logic [pdrg_pkg::SHIFT_WIDTH-1:0]    shift_ff [3];
   logic [pdrg_pkg::RANGE_WIDTH-1:0]    range_ff;
   logic [pdrg_pkg::KEEP_WIDTH-1:0]     keep_ff;
   logic [pdrg_pkg::RANGE_SQ_WIDTH-1:0] min_sq_ff, max_sq_ff;
   logic [pdrg_pkg::RANGE_SQ_WIDTH-1:0] min_sq_in, max_sq_in;
   pdrg_pkg::csr_index_type             csr_sel;

   assign csr_ready = 1'b1;
   assign csr_sel   = pdrg_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= pdrg_pkg::ROT_ROW_X_RESET;
         rot_ff[1]   <= pdrg_pkg::ROT_ROW_Y_RESET;
         rot_ff[2]   <= pdrg_pkg::ROT_ROW_Z_RESET;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
         range_ff    <= pdrg_pkg::RANGE_RESET;
         keep_ff     <= pdrg_pkg::KEEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_sel)
            pdrg_pkg::REG_ROT_ROW_X:  rot_ff[0]   <= csr_data[pdrg_pkg::ROW_WIDTH-1:0];
            pdrg_pkg::REG_ROT_ROW_Y:  rot_ff[1]   <= csr_data[pdrg_pkg::ROW_WIDTH-1:0];
            pdrg_pkg::REG_ROT_ROW_Z:  rot_ff[2]   <= csr_data[pdrg_pkg::ROW_WIDTH-1:0];
            pdrg_pkg::REG_SHIFT_X:    shift_ff[0] <= csr_data[pdrg_pkg::SHIFT_WIDTH-1:0];
            pdrg_pkg::REG_SHIFT_Y:    shift_ff[1] <= csr_data[pdrg_pkg::SHIFT_WIDTH-1:0];
            pdrg_pkg::REG_SHIFT_Z:    shift_ff[2] <= csr_data[pdrg_pkg::SHIFT_WIDTH-1:0];
            pdrg_pkg::REG_RANGE:      range_ff    <= csr_data[pdrg_pkg::RANGE_WIDTH-1:0];
            pdrg_pkg::REG_KEEP_EVERY: keep_ff     <= csr_data[pdrg_pkg::KEEP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // squared limits, recomputed every cycle from the range register
   assign min_sq_in = pdrg_pkg::RANGE_SQ_WIDTH'(range_ff[pdrg_pkg::RANGE_FIELD-1:0]) *
                      pdrg_pkg::RANGE_SQ_WIDTH'(range_ff[pdrg_pkg::RANGE_FIELD-1:0]);
   assign max_sq_in = pdrg_pkg::RANGE_SQ_WIDTH'(range_ff[pdrg_pkg::RANGE_WIDTH-1:
                                                         pdrg_pkg::RANGE_FIELD]) *
                      pdrg_pkg::RANGE_SQ_WIDTH'(range_ff[pdrg_pkg::RANGE_WIDTH-1:
                                                         pdrg_pkg::RANGE_FIELD]);

   always_ff @(posedge clock) begin
      min_sq_ff <= min_sq_in;
      max_sq_ff <= max_sq_in;
   end

   // ---------------- pipeline control ----------------
   logic in_valid_ff, mul_valid_ff, out_valid_ff;
   logic in_ready, mul_ready, out_ready;
   logic req_fire;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign mul_ready  = !mul_valid_ff || out_ready;
   assign in_ready   = !in_valid_ff  || mul_ready;
   assign req_tready = in_ready;
   assign req_fire   = req_tvalid && in_ready;

   // ---------------- decimation ----------------
   logic [pdrg_pkg::KEEP_WIDTH-1:0] phase_ff, phase_in, phase_cur, keep_n;
   logic [pdrg_pkg::KEEP_WIDTH:0]   phase_inc;
   logic                            keep_point;

   assign phase_cur  = req_tuser ? '0 : phase_ff;
   assign keep_point = (phase_cur == '0);
   assign keep_n     = (keep_ff == '0) ? pdrg_pkg::KEEP_WIDTH'(1) : keep_ff;
   assign phase_inc  = {1'b0, phase_cur} + (pdrg_pkg::KEEP_WIDTH+1)'(1);
   assign phase_in   = (phase_inc >= {1'b0, keep_n}) ? '0 :
                       phase_inc[pdrg_pkg::KEEP_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         in_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) phase_ff <= phase_in;
         if (in_ready)  in_valid_ff  <= req_fire && keep_point;
         if (mul_ready) mul_valid_ff <= in_valid_ff;
         if (out_ready) out_valid_ff <= mul_valid_ff;
      end
   end

   // ---------------- input register ----------------
   logic signed [COORD_WIDTH-1:0] pt_ff [3];
   logic signed [COORD_WIDTH-1:0] pt_in [3];

   // ---------------- multiplier register ----------------
   logic signed [COEF_WIDTH-1:0]  coef    [3][3];
   logic signed [PROD_WIDTH-1:0]  prod_ff [3][3];
   logic signed [PROD_WIDTH-1:0]  prod_in [3][3];
   logic signed [SQ_WIDTH-1:0]    sq_ff   [3];
   logic signed [SQ_WIDTH-1:0]    sq_in   [3];
   logic [ROW_EXT-1:0]            row_ext [3];

   for (genvar k = 0; k < 3; k++) begin : g_coord
      assign pt_in[k] = signed'(req_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
      assign sq_in[k] = SQ_WIDTH'(pt_ff[k]) * SQ_WIDTH'(pt_ff[k]);
   end

   for (genvar r = 0; r < 3; r++) begin : g_row_mul
      // coefficients past bit 47 of the row read as zero
      assign row_ext[r] = ROW_EXT'(rot_ff[r]);
      for (genvar k = 0; k < 3; k++) begin : g_col
         assign coef[r][k]    = signed'(row_ext[r][k*COEF_WIDTH +: COEF_WIDTH]);
         assign prod_in[r][k] = PROD_WIDTH'(coef[r][k]) * PROD_WIDTH'(pt_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && keep_point && in_ready) begin
         pt_ff <= pt_in;
      end
      if (in_valid_ff && mul_ready) begin
         prod_ff <= prod_in;
         sq_ff   <= sq_in;
      end
   end

   // ---------------- gate, round, translate, clip ----------------
   logic [SQ_WIDTH-1:0]            norm_sq;
   logic                           gate_in;
   logic signed [ACC_WIDTH-1:0]    acc     [3];
   logic signed [ACC_WIDTH-1:0]    scaled  [3];
   logic signed [ACC_WIDTH-1:0]    moved   [3];
   logic [SH_EXT-1:0]              sh_ext  [3];
   logic signed [COORD_WIDTH-1:0]  sh_cw   [3];
   logic [HEAD_WIDTH-1:0]          head    [3];
   logic [2:0]                     clip;
   logic [COORD_WIDTH-1:0]         world_in [3];
   logic [COORD_WIDTH-1:0]         world_ff [3];
   logic                           gate_ff, sat_ff;

   // norm fits: three squares stay below 2^(2*COORD_WIDTH)
   assign norm_sq = $unsigned(sq_ff[0]) + $unsigned(sq_ff[1]) + $unsigned(sq_ff[2]);
   assign gate_in = (CMP_WIDTH'(norm_sq) < CMP_WIDTH'(min_sq_ff)) ||
                    (CMP_WIDTH'(norm_sq) > CMP_WIDTH'(max_sq_ff));

   for (genvar r = 0; r < 3; r++) begin : g_row_out
      // a zeroed point gives a zero sum, which rounds to zero
      assign acc[r]    = gate_in ? '0 :
                         ACC_WIDTH'(prod_ff[r][0]) + ACC_WIDTH'(prod_ff[r][1]) +
                         ACC_WIDTH'(prod_ff[r][2]);
      assign scaled[r] = (acc[r] + ROUND_HALF) >>> FRAC_SHIFT;
      assign sh_ext[r] = SH_EXT'(shift_ff[r]);
      assign sh_cw[r]  = signed'(sh_ext[r][COORD_WIDTH-1:0]);
      assign moved[r]  = scaled[r] + ACC_WIDTH'(sh_cw[r]);
      assign head[r]   = moved[r][ACC_WIDTH-1:COORD_WIDTH-1];
      assign clip[r]   = !((&head[r]) || (~|head[r]));
      assign world_in[r] = !clip[r] ? moved[r][COORD_WIDTH-1:0] :
                           moved[r][ACC_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} :
                                                   {1'b0, {(COORD_WIDTH-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (mul_valid_ff && out_ready) begin
         world_ff <= world_in;
         gate_ff  <= gate_in;
         sat_ff   <= |clip;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_WIDTH{1'b0}}, world_ff[2], world_ff[1], world_ff[0]};
   assign rsp_tuser  = {sat_ff, gate_ff};

endmodule
